[sv/raas_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package raas_pkg;
    localparam int COORD_W = 32;
    localparam int DIST_W  = 47;
    localparam int NZL_W   = 17;
    localparam int NAXIS   = 3;
    localparam int NLANE   = 2 * NAXIS;
    localparam int DEN_W   = COORD_W;
    localparam int REM_W   = COORD_W;
    localparam int CFG_DW  = 64;
    localparam int CFG_AW  = 4;

    localparam logic REG_MAX_DISTANCE   = 1'b0;
    localparam logic REG_NEAR_ZERO_LIMIT = 1'b1;

    typedef struct packed {
        logic parallel;
        logic in_slab;
    } t_axis_ctl;
endpackage
`default_nettype wire

[sv/raas_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module raas_div_cell
    import raas_pkg::*;
#(
    parameter int QW = 49
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [REM_W-1:0]      i_rem [NLANE],
    input  wire logic [QW-1:0]         i_dq  [NLANE],
    input  wire logic [DEN_W-1:0]      i_den [NAXIS],
    input  wire logic [NLANE-1:0]      i_neg,
    input  wire t_axis_ctl             i_ctl [NAXIS],
    output logic      [REM_W-1:0]      o_rem [NLANE],
    output logic      [QW-1:0]         o_dq  [NLANE],
    output logic      [DEN_W-1:0]      o_den [NAXIS],
    output logic      [NLANE-1:0]      o_neg,
    output t_axis_ctl                  o_ctl [NAXIS]
);
    logic [REM_W-1:0] n_rem [NLANE];
    logic [QW-1:0]    n_dq  [NLANE];

    always_comb begin
        logic [REM_W:0] t;
        logic [REM_W:0] d;
        for (int l = 0; l < NLANE; l++) begin
            t = {i_rem[l], i_dq[l][QW-1]};
            d = {1'b0, i_den[l/2]};
            if (t >= d) begin
                n_rem[l] = REM_W'(t - d);
                n_dq[l]  = {i_dq[l][QW-2:0], 1'b1};
            end else begin
                n_rem[l] = REM_W'(t);
                n_dq[l]  = {i_dq[l][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= n_rem;
            o_dq  <= n_dq;
            o_den <= i_den;
            o_neg <= i_neg;
            o_ctl <= i_ctl;
        end
    end
endmodule
`default_nettype wire

[sv/raas_slab_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module raas_slab_cell
    import raas_pkg::*;
#(
    parameter int AXIS = 0,
    parameter int QW   = 49,
    parameter int TW   = 50
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [QW-1:0]         i_q   [NLANE],
    input  wire logic [NLANE-1:0]      i_neg,
    input  wire t_axis_ctl             i_ctl [NAXIS],
    input  wire logic                  i_ok,
    input  wire logic signed [TW-1:0]  i_near,
    input  wire logic signed [TW-1:0]  i_far,
    output logic      [QW-1:0]         o_q   [NLANE],
    output logic      [NLANE-1:0]      o_neg,
    output t_axis_ctl                  o_ctl [NAXIS],
    output logic                       o_ok,
    output logic signed [TW-1:0]       o_near,
    output logic signed [TW-1:0]       o_far
);
    logic              n_ok;
    logic signed [TW-1:0] n_near;
    logic signed [TW-1:0] n_far;

    always_comb begin
        logic signed [TW-1:0] qa;
        logic signed [TW-1:0] qb;
        logic signed [TW-1:0] ta;
        logic signed [TW-1:0] tb;
        qa = $signed(TW'(i_q[2*AXIS]));
        qb = $signed(TW'(i_q[2*AXIS+1]));
        if (i_neg[2*AXIS])   qa = -qa;
        if (i_neg[2*AXIS+1]) qb = -qb;
        ta = (qa > qb) ? qb : qa;
        tb = (qa > qb) ? qa : qb;
        n_ok   = i_ok;
        n_near = i_near;
        n_far  = i_far;
        if (i_ok) begin
            if (i_ctl[AXIS].parallel) begin
                n_ok = i_ctl[AXIS].in_slab;
            end else if (tb < i_near || ta > i_far) begin
                n_ok = 1'b0;
            end else begin
                if (ta > i_near) n_near = ta;
                if (tb < i_far)  n_far  = tb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q    <= i_q;
            o_neg  <= i_neg;
            o_ctl  <= i_ctl;
            o_ok   <= n_ok;
            o_near <= n_near;
            o_far  <= n_far;
        end
    end
endmodule
`default_nettype wire

[sv/ray_aabb_slab_test_core.sv]
// Ray versus axis-aligned box slab test.
// Input channel: i_valid / o_stall with the ray origin, direction and box
// corners (signed fixed point, FRAC_BITS fraction bits). A transaction is
// taken at each rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_hit and o_t_entry (entry distance,
// zero on a miss).
// Throughput: one transaction per cycle while the receiver does not stall.
// Pipeline: one entry stage, one restoring-division cell per quotient bit,
// one cell per slab axis, the last of which is the output register.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles are squeezed out while the receiver stalls; o_stall rises only
// when every stage holds a transaction.
// Configuration: APB port, max_distance at byte 0, near_zero_limit at byte 8;
// write only while the block is idle.
// Reset (synchronous, active low) empties the pipeline and restores
// max_distance to 100000.0 and near_zero_limit to one LSB.
`timescale 1ns / 1ps
`default_nettype none
module ray_aabb_slab_test_core
    import raas_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [CFG_AW-1:0]          paddr,
    input  wire logic [CFG_DW-1:0]          pwdata,
    output logic      [CFG_DW-1:0]          prdata,
    output logic                            pready,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic signed [COORD_W-1:0]  i_origin_x,
    input  wire logic signed [COORD_W-1:0]  i_origin_y,
    input  wire logic signed [COORD_W-1:0]  i_origin_z,
    input  wire logic signed [COORD_W-1:0]  i_dir_x,
    input  wire logic signed [COORD_W-1:0]  i_dir_y,
    input  wire logic signed [COORD_W-1:0]  i_dir_z,
    input  wire logic signed [COORD_W-1:0]  i_box_min_x,
    input  wire logic signed [COORD_W-1:0]  i_box_min_y,
    input  wire logic signed [COORD_W-1:0]  i_box_min_z,
    input  wire logic signed [COORD_W-1:0]  i_box_max_x,
    input  wire logic signed [COORD_W-1:0]  i_box_max_y,
    input  wire logic signed [COORD_W-1:0]  i_box_max_z,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic                            o_hit,
    output logic      [DIST_W-1:0]          o_t_entry
);
    localparam int NUM_W = COORD_W + 1;
    localparam int QW    = NUM_W + FRAC_BITS;
    localparam int TW    = (QW + 1 > DIST_W + 1) ? QW + 1 : DIST_W + 1;
    localparam int NSTG  = 1 + QW + NAXIS;
    localparam logic [63:0] MAXD_RST64 = 64'd100000 << FRAC_BITS;
    localparam logic [DIST_W-1:0] MAXD_RST = MAXD_RST64[DIST_W-1:0];

    logic [DIST_W-1:0] r_max_distance;
    logic [NZL_W-1:0]  r_near_zero_limit;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_distance    <= MAXD_RST;
            r_near_zero_limit <= NZL_W'(1);
        end else if (cfg_wr) begin
            if (paddr[3] == REG_MAX_DISTANCE) r_max_distance <= pwdata[DIST_W-1:0];
            else                              r_near_zero_limit <= pwdata[NZL_W-1:0];
        end
    end

    always_comb begin
        if (paddr[3] == REG_MAX_DISTANCE) prdata = CFG_DW'(r_max_distance);
        else                              prdata = CFG_DW'(r_near_zero_limit);
    end

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    logic signed [COORD_W-1:0] org [NAXIS];
    logic signed [COORD_W-1:0] dir [NAXIS];
    logic signed [COORD_W-1:0] bmn [NAXIS];
    logic signed [COORD_W-1:0] bmx [NAXIS];

    assign org = '{i_origin_x, i_origin_y, i_origin_z};
    assign dir = '{i_dir_x, i_dir_y, i_dir_z};
    assign bmn = '{i_box_min_x, i_box_min_y, i_box_min_z};
    assign bmx = '{i_box_max_x, i_box_max_y, i_box_max_z};

    logic [REM_W-1:0] n_rem0 [NLANE];
    logic [QW-1:0]    n_dq0  [NLANE];
    logic [DEN_W-1:0] n_den0 [NAXIS];
    logic [NLANE-1:0] n_neg0;
    t_axis_ctl        n_ctl0 [NAXIS];

    always_comb begin
        logic signed [NUM_W-1:0] num;
        logic [NUM_W-1:0]        nm;
        logic [DEN_W-1:0]        dm;
        for (int a = 0; a < NAXIS; a++) begin
            dm = dir[a][COORD_W-1] ? DEN_W'(-dir[a]) : DEN_W'(dir[a]);
            n_den0[a] = dm;
            n_ctl0[a].parallel = (dir[a] == '0) ||
                                 ({1'b0, dm} < (DEN_W + 1)'(r_near_zero_limit));
            n_ctl0[a].in_slab = (org[a] < bmx[a]) && (org[a] > bmn[a]);
            for (int s = 0; s < 2; s++) begin
                num = (s == 0) ? (NUM_W'(bmn[a]) - NUM_W'(org[a]))
                               : (NUM_W'(bmx[a]) - NUM_W'(org[a]));
                nm = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                n_rem0[2*a+s] = '0;
                n_dq0[2*a+s]  = {nm, {FRAC_BITS{1'b0}}};
                n_neg0[2*a+s] = num[NUM_W-1] ^ dir[a][COORD_W-1];
            end
        end
    end

    logic [REM_W-1:0] s_rem [QW+1][NLANE];
    logic [QW-1:0]    s_dq  [QW+1][NLANE];
    logic [DEN_W-1:0] s_den [QW+1][NAXIS];
    logic [NLANE-1:0] s_neg [QW+1];
    t_axis_ctl        s_ctl [QW+1][NAXIS];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            s_rem[0] <= n_rem0;
            s_dq[0]  <= n_dq0;
            s_den[0] <= n_den0;
            s_neg[0] <= n_neg0;
            s_ctl[0] <= n_ctl0;
        end
    end

    for (genvar g = 0; g < QW; g++) begin : g_div
        raas_div_cell #(.QW(QW)) u_cell (
            .i_clk (i_clk),
            .i_en  (en[g+1]),
            .i_rem (s_rem[g]),
            .i_dq  (s_dq[g]),
            .i_den (s_den[g]),
            .i_neg (s_neg[g]),
            .i_ctl (s_ctl[g]),
            .o_rem (s_rem[g+1]),
            .o_dq  (s_dq[g+1]),
            .o_den (s_den[g+1]),
            .o_neg (s_neg[g+1]),
            .o_ctl (s_ctl[g+1])
        );
    end

    logic [QW-1:0]        c_q    [NAXIS+1][NLANE];
    logic [NLANE-1:0]     c_neg  [NAXIS+1];
    t_axis_ctl            c_ctl  [NAXIS+1][NAXIS];
    logic                 c_ok   [NAXIS+1];
    logic signed [TW-1:0] c_near [NAXIS+1];
    logic signed [TW-1:0] c_far  [NAXIS+1];

    assign c_q[0]    = s_dq[QW];
    assign c_neg[0]  = s_neg[QW];
    assign c_ctl[0]  = s_ctl[QW];
    assign c_ok[0]   = 1'b1;
    assign c_near[0] = '0;
    assign c_far[0]  = $signed(TW'(r_max_distance));

    for (genvar g = 0; g < NAXIS; g++) begin : g_slab
        raas_slab_cell #(.AXIS(g), .QW(QW), .TW(TW)) u_cell (
            .i_clk  (i_clk),
            .i_en   (en[QW+1+g]),
            .i_q    (c_q[g]),
            .i_neg  (c_neg[g]),
            .i_ctl  (c_ctl[g]),
            .i_ok   (c_ok[g]),
            .i_near (c_near[g]),
            .i_far  (c_far[g]),
            .o_q    (c_q[g+1]),
            .o_neg  (c_neg[g+1]),
            .o_ctl  (c_ctl[g+1]),
            .o_ok   (c_ok[g+1]),
            .o_near (c_near[g+1]),
            .o_far  (c_far[g+1])
        );
    end

    assign o_hit     = c_ok[NAXIS];
    assign o_t_entry = c_ok[NAXIS] ? c_near[NAXIS][DIST_W-1:0] : '0;

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with an empty output stage");

    a_hit_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_t_entry <= r_max_distance))
        else $error("entry distance beyond max_distance");

    a_near_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (c_near[NAXIS] >= 0 && c_near[NAXIS] <= c_far[NAXIS]))
        else $error("interval inverted on a hit");
endmodule
`default_nettype wire

[verif/ray_aabb_slab_test_core_checker.sv]
`timescale 1ns / 1ps
module ray_aabb_slab_test_core_checker
    import raas_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [CFG_AW-1:0]         paddr,
    input  wire logic [CFG_DW-1:0]         pwdata,
    input  wire logic                      pready,
    input  wire logic                      i_valid,
    input  wire logic                      o_stall,
    input  wire logic [11:0][COORD_W-1:0]  i_ray_box,
    input  wire logic                      o_valid,
    input  wire logic                      i_stall,
    input  wire logic                      o_hit,
    input  wire logic [DIST_W-1:0]         o_t_entry,
    output int                             o_errors,
    output int                             o_pending
);
    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] t_entry;
    } t_slab_result;

    localparam logic [CFG_AW-1:0] ADDR_MAX_DISTANCE    = {REG_MAX_DISTANCE, 3'b000};
    localparam logic [CFG_AW-1:0] ADDR_NEAR_ZERO_LIMIT = {REG_NEAR_ZERO_LIMIT, 3'b000};

    logic [DIST_W-1:0] max_distance_q;
    logic [NZL_W-1:0]  near_zero_limit_q;
    t_slab_result      hit_queue[$];

    function automatic longint slab_quotient(input longint num, input longint den);
        longint unsigned num_mag;
        longint unsigned den_mag;
        longint unsigned quo;
        num_mag = (num < 0) ? -num : num;
        den_mag = (den < 0) ? -den : den;
        quo = (num_mag << FRAC_BITS) / den_mag;
        return ((num < 0) != (den < 0)) ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic t_slab_result slab_hit(input logic [11:0][COORD_W-1:0] f);
        t_slab_result res;
        longint org, dir, lo, hi, ta, tb, tt, t_near, t_far;
        longint unsigned dir_mag;
        bit ok;
        t_near = 0;
        t_far  = longint'({17'd0, max_distance_q});
        ok     = 1'b1;
        for (int a = 0; a < NAXIS; a++) begin
            if (ok) begin
                org = longint'($signed(f[a]));
                dir = longint'($signed(f[3 + a]));
                lo  = longint'($signed(f[6 + a]));
                hi  = longint'($signed(f[9 + a]));
                dir_mag = (dir < 0) ? -dir : dir;
                if (dir == 0 || dir_mag < longint'({47'd0, near_zero_limit_q})) begin
                    ok = (org < hi) && (org > lo);
                end else begin
                    ta = slab_quotient(lo - org, dir);
                    tb = slab_quotient(hi - org, dir);
                    if (ta > tb) begin
                        tt = ta;
                        ta = tb;
                        tb = tt;
                    end
                    if (tb < t_near || ta > t_far) begin
                        ok = 1'b0;
                    end else begin
                        if (ta > t_near) t_near = ta;
                        if (tb < t_far) t_far = tb;
                    end
                end
            end
        end
        res.hit     = ok;
        res.t_entry = ok ? t_near[DIST_W-1:0] : '0;
        return res;
    endfunction

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_slab_result exp_res;
        int           n_err;
        n_err = 0;
        if (!i_rst_n) begin
            max_distance_q    <= DIST_W'(64'd100000 << FRAC_BITS);
            near_zero_limit_q <= NZL_W'(1);
            hit_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_MAX_DISTANCE) max_distance_q <= pwdata[DIST_W-1:0];
                if (paddr == ADDR_NEAR_ZERO_LIMIT) near_zero_limit_q <= pwdata[NZL_W-1:0];
            end
            if (i_valid && !o_stall) hit_queue = {hit_queue, slab_hit(i_ray_box)};
            if (o_valid && !i_stall) begin
                if (hit_queue.size() == 0) begin
                    $error("unexpected transaction: hit %0d t_entry %0d", o_hit, o_t_entry);
                    n_err++;
                end else begin
                    exp_res = hit_queue.pop_front();
                    if (o_hit !== exp_res.hit) begin
                        $error("hit: expected %0d actual %0d", exp_res.hit, o_hit);
                        n_err++;
                    end
                    if (o_t_entry !== exp_res.t_entry) begin
                        $error("t_entry: expected %0d actual %0d", exp_res.t_entry, o_t_entry);
                        n_err++;
                    end
                end
            end
        end
        o_errors  <= o_errors + n_err;
        o_pending <= hit_queue.size();
    end
endmodule

[verif/ray_aabb_slab_test_core_test.sv]
`timescale 1ns / 1ps
module ray_aabb_slab_test_core_test;
    import raas_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam logic [CFG_AW-1:0] ADDR_MAX_DISTANCE    = {REG_MAX_DISTANCE, 3'b000};
    localparam logic [CFG_AW-1:0] ADDR_NEAR_ZERO_LIMIT = {REG_NEAR_ZERO_LIMIT, 3'b000};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [CFG_DW-1:0] pwdata = '0;
    logic [CFG_DW-1:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [11:0][COORD_W-1:0] ray_box = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_hit;
    logic [DIST_W-1:0] o_t_entry;
    int errors;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    logic hold_start = 1'b0;

    always #4 i_clk = ~i_clk;

    ray_aabb_slab_test_core #(.FRAC_BITS(FRAC_BITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_origin_x(ray_box[0]), .i_origin_y(ray_box[1]), .i_origin_z(ray_box[2]),
        .i_dir_x(ray_box[3]), .i_dir_y(ray_box[4]), .i_dir_z(ray_box[5]),
        .i_box_min_x(ray_box[6]), .i_box_min_y(ray_box[7]), .i_box_min_z(ray_box[8]),
        .i_box_max_x(ray_box[9]), .i_box_max_y(ray_box[10]), .i_box_max_z(ray_box[11]),
        .o_valid(o_valid), .i_stall(i_stall), .o_hit(o_hit), .o_t_entry(o_t_entry)
    );

    ray_aabb_slab_test_core_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall), .i_ray_box(ray_box),
        .o_valid(o_valid), .i_stall(i_stall), .o_hit(o_hit), .o_t_entry(o_t_entry),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left <= 400;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_ray(input logic [11:0][COORD_W-1:0] f);
        int gap;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(4, 1);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        ray_box <= f;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        if (i_valid) i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [11:0][COORD_W-1:0] random_ray();
        logic [11:0][COORD_W-1:0] f;
        longint lo, span, org, ctr;
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            for (int k = 0; k < 12; k++) f[k] = $urandom;
            return f;
        end
        for (int a = 0; a < 3; a++) begin
            lo   = longint'($signed($urandom)) >>> $urandom_range(14, 8);
            span = longint'($urandom_range(32'h0020_0000, 1));
            org  = longint'($signed($urandom)) >>> $urandom_range(12, 6);
            ctr  = lo + span / 2;
            f[a]     = COORD_W'(org);
            f[6 + a] = COORD_W'(lo);
            f[9 + a] = COORD_W'(lo + span);
            f[3 + a] = COORD_W'((ctr - org) >>> $urandom_range(6, 0));
            if (sel < 35 && $urandom_range(3) == 0) f[3 + a] = COORD_W'($urandom_range(3));
            if (sel < 45 && $urandom_range(3) == 0) f[3 + a] = COORD_W'(-$urandom_range(70000));
            if (sel < 50 && $urandom_range(5) == 0) begin
                f[6 + a] = COORD_W'(lo + span);
                f[9 + a] = COORD_W'(lo);
            end
        end
        return f;
    endfunction

    task automatic directed_rays();
        logic [11:0][COORD_W-1:0] f;
        f = {12{32'h7fff_ffff}};
        send_ray(f);
        f = {12{32'h8000_0000}};
        send_ray(f);
        f = '0;
        send_ray(f);
        for (int a = 0; a < 3; a++) begin
            f[a] = 32'h0001_0000;
            f[3 + a] = '0;
            f[6 + a] = '0;
            f[9 + a] = 32'h0002_0000;
        end
        send_ray(f);
        f[0] = '0;
        send_ray(f);
        f[0] = 32'h0002_0000;
        send_ray(f);
        f[3] = 32'h0000_0001;
        f[0] = 32'hfff0_0000;
        send_ray(f);
        f[3] = 32'h8000_0000;
        f[0] = 32'h7fff_ffff;
        send_ray(f);
        f[3] = 32'h7fff_ffff;
        f[0] = 32'h8000_0000;
        send_ray(f);
        for (int a = 0; a < 3; a++) begin
            f[a] = 32'hfffe_0000;
            f[3 + a] = 32'h0001_0000;
            f[6 + a] = 32'h0003_0000;
            f[9 + a] = 32'h0001_0000;
        end
        send_ray(f);
        for (int a = 0; a < 3; a++) begin
            f[a] = 32'h8000_0000;
            f[3 + a] = 32'h0000_0001;
            f[6 + a] = 32'h8000_0000;
            f[9 + a] = 32'h7fff_ffff;
        end
        send_ray(f);
        f[4] = 32'hffff_ffff;
        f[1] = 32'h7fff_ffff;
        send_ray(f);
        f[5] = 32'h0000_8000;
        send_ray(f);
        f[3] = 32'hffff_0000;
        f[0] = 32'h0010_0000;
        send_ray(f);
        for (int k = 0; k < 6; k++) send_ray(random_ray());
    endtask

    initial begin
        #(3_000_000);
        $display("ray_aabb_slab_test_core: mismatch");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        for (int p = 0; p < 7; p++) begin
            case (p)
                1: begin
                    write_reg(ADDR_MAX_DISTANCE, '0);
                    write_reg(ADDR_NEAR_ZERO_LIMIT, '0);
                end
                2: begin
                    write_reg(ADDR_MAX_DISTANCE, 64'h0000_7fff_ffff_ffff);
                    write_reg(ADDR_NEAR_ZERO_LIMIT, 64'h0001_0000);
                end
                3: begin
                    write_reg(ADDR_MAX_DISTANCE, 64'h0000_0000_0010_0000);
                    write_reg(ADDR_NEAR_ZERO_LIMIT, 64'h2);
                end
                4, 5, 6: begin
                    write_reg(ADDR_MAX_DISTANCE, {$urandom, $urandom} & 64'h0000_7fff_ffff_ffff);
                    write_reg(ADDR_NEAR_ZERO_LIMIT, $urandom_range(65536));
                end
                default: ;
            endcase
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            if (p == 0 || p == 2) directed_rays();
            if (p == 0) begin
                i_valid    <= 1'b0;
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
            end
            repeat (p == 0 ? 120 : 70) send_ray(random_ray());
            drain();
        end
        if (errors == 0) begin
            $display("ray_aabb_slab_test_core: match");
        end else begin
            $display("ray_aabb_slab_test_core: mismatch");
        end
        $finish;
    end
endmodule
